// ----- rtl/mcpwm_pkg.sv -----
// Shared types and constants for the multichannel PWM pin-mask generator.
package mcpwm_pkg;

    localparam int DUTY_W = 8;
    localparam int PIN_W  = 6;
    localparam int MASK_W = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_FILL
    } t_state;

    typedef enum logic [1:0] {
        A_TICK    = 2'd0,
        A_SET_ONE = 2'd1,
        A_SET_ALL = 2'd2,
        A_MAP_PIN = 2'd3
    } t_action;

    typedef struct packed {
        logic              duty_we;
        logic              pin_we;
        logic [DUTY_W-1:0] duty;
        logic [PIN_W-1:0]  pin;
    } t_mem_req;

endpackage

// ----- rtl/mcpwm_mem.sv -----
// Duty and pin tables: synchronous memories with per-entry valid bits.
module mcpwm_mem #(
    parameter int CHANNELS = 16,
    parameter int AW       = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mcpwm_pkg::t_mem_req          i_req,
    input  logic [AW-1:0]                i_waddr,
    input  logic [AW-1:0]                i_raddr,
    output logic [mcpwm_pkg::DUTY_W-1:0] o_rd_duty,
    output logic [mcpwm_pkg::PIN_W-1:0]  o_rd_pin
);
    import mcpwm_pkg::*;

    logic [DUTY_W-1:0]   r_duty_mem [CHANNELS];
    logic [PIN_W-1:0]    r_pin_mem  [CHANNELS];
    logic [CHANNELS-1:0] r_duty_vld;
    logic [CHANNELS-1:0] r_pin_vld;
    logic [DUTY_W-1:0]   r_rd_duty;
    logic [PIN_W-1:0]    r_rd_pin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_vld <= '0;
            r_pin_vld  <= '0;
        end else begin
            if (i_req.duty_we) begin
                r_duty_vld[i_waddr] <= 1'b1;
            end
            if (i_req.pin_we) begin
                r_pin_vld[i_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.duty_we) begin
            r_duty_mem[i_waddr] <= i_req.duty;
        end
        if (i_req.pin_we) begin
            r_pin_mem[i_waddr] <= i_req.pin;
        end
        r_rd_duty <= r_duty_vld[i_raddr] ? r_duty_mem[i_raddr] : '0;
        r_rd_pin  <= r_pin_vld[i_raddr] ? r_pin_mem[i_raddr] : '0;
    end

    assign o_rd_duty = r_rd_duty;
    assign o_rd_pin  = r_rd_pin;

endmodule

// ----- rtl/mcpwm_ctrl.sv -----
// Request sequencer: table walk for ticks, duty fill, mask accumulation, phase counter.
module mcpwm_ctrl #(
    parameter int CHANNELS   = 16,
    parameter int RESOLUTION = 8,
    parameter int AW         = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [4:0]                   i_cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_action,
    input  logic [3:0]                   i_channel,
    input  logic [15:0]                  i_duty,
    input  logic [5:0]                   i_pin,
    output logic                         o_strobe,
    output logic [31:0]                  o_set_low,
    output logic [31:0]                  o_clear_low,
    output logic [31:0]                  o_set_high,
    output logic [31:0]                  o_clear_high,
    output logic                         o_error,
    output mcpwm_pkg::t_mem_req          o_req,
    output logic [AW-1:0]                o_waddr,
    output logic [AW-1:0]                o_raddr,
    input  logic [mcpwm_pkg::DUTY_W-1:0] i_rd_duty,
    input  logic [mcpwm_pkg::PIN_W-1:0]  i_rd_pin
);
    import mcpwm_pkg::*;

    localparam int LW = $clog2(CHANNELS + 1);

    t_state            r_state, n_state;
    logic [LW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_strobe, n_strobe;
    logic [RESOLUTION-1:0] r_phase, n_phase;
    logic [4:0]        r_active;
    logic [MASK_W-1:0] r_mask [4];
    logic [MASK_W-1:0] n_mask [4];
    logic              r_err, n_err;
    logic [DUTY_W-1:0] r_wduty, n_wduty;
    logic [LW-1:0]     live;
    logic              on;

    assign live = (32'(r_active) > 32'(CHANNELS)) ? LW'(CHANNELS) : LW'(r_active);
    assign on   = i_rd_duty > DUTY_W'(r_phase);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_strobe = 1'b0;
        n_phase  = r_phase;
        n_mask   = r_mask;
        n_err    = r_err;
        n_wduty  = r_wduty;
        o_req    = '0;
        o_waddr  = r_idx[AW-1:0];
        o_raddr  = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mask = '{default: '0};
                    n_err  = 1'b0;
                    n_idx  = '0;
                    case (t_action'(i_action))
                        A_TICK: begin
                            n_state = S_TICK;
                        end
                        A_SET_ONE: begin
                            if (32'(i_channel) >= 32'(live)) begin
                                n_err = 1'b1;
                            end else begin
                                o_req.duty_we = 1'b1;
                                o_req.duty    = i_duty[15:8];
                                o_waddr       = AW'(i_channel);
                            end
                            n_strobe = 1'b1;
                        end
                        A_SET_ALL: begin
                            n_wduty = i_duty[15:8];
                            n_state = S_FILL;
                        end
                        A_MAP_PIN: begin
                            if (32'(i_channel) < 32'(CHANNELS)) begin
                                o_req.pin_we = 1'b1;
                                o_req.pin    = i_pin;
                                o_waddr      = AW'(i_channel);
                            end
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (r_idx < live) begin
                    n_idx  = LW'(r_idx + 1'b1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    n_mask[{i_rd_pin[5], ~on}] = r_mask[{i_rd_pin[5], ~on}]
                                                 | (MASK_W'(1) << i_rd_pin[4:0]);
                end
                if (r_idx == live && !r_pend) begin
                    n_strobe = 1'b1;
                    n_phase  = r_phase + 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_FILL: begin
                if (r_idx < live) begin
                    o_req.duty_we = 1'b1;
                    o_req.duty    = r_wduty;
                    n_idx         = LW'(r_idx + 1'b1);
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
            r_phase  <= '0;
            r_active <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
            r_phase  <= n_phase;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask  <= n_mask;
        r_err   <= n_err;
        r_wduty <= n_wduty;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_set_low    = r_mask[0];
    assign o_clear_low  = r_mask[1];
    assign o_set_high   = r_mask[2];
    assign o_clear_high = r_mask[3];
    assign o_error      = r_err;

endmodule

// ----- rtl/multichannel_pwm_pin_masks_top.sv -----
// Top level of the multichannel PWM pin-mask generator.
// A request is taken when start is high and busy is low. Its result appears on the output
// ports for one cycle with o_strobe high and must be captured then, since the receiver
// cannot stall the block. The live count is the active count capped at CHANNELS. A tick
// walks the duty and pin tables one channel per cycle through the table read port. Busy
// stays high for the walk, also when no channel is live, and the result appears in the
// cycle in which busy falls. Set-all writes one channel per cycle through the table write
// port while busy is high, and the result likewise appears as busy falls. Set-one and
// map-pin complete in the request cycle, busy stays low and the result follows in the
// next cycle.
module multichannel_pwm_pin_masks_top #(
    parameter int CHANNELS   = 16,
    parameter int RESOLUTION = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_channel,
    input  logic [15:0] i_duty,
    input  logic [5:0]  i_pin,
    output logic        o_strobe,
    output logic [31:0] o_set_low,
    output logic [31:0] o_clear_low,
    output logic [31:0] o_set_high,
    output logic [31:0] o_clear_high,
    output logic        o_error
);
    import mcpwm_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_mem_req          req;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [DUTY_W-1:0] rd_duty;
    logic [PIN_W-1:0]  rd_pin;

    mcpwm_ctrl #(
        .CHANNELS   (CHANNELS),
        .RESOLUTION (RESOLUTION),
        .AW         (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_channel    (i_channel),
        .i_duty       (i_duty),
        .i_pin        (i_pin),
        .o_strobe     (o_strobe),
        .o_set_low    (o_set_low),
        .o_clear_low  (o_clear_low),
        .o_set_high   (o_set_high),
        .o_clear_high (o_clear_high),
        .o_error      (o_error),
        .o_req        (req),
        .o_waddr      (waddr),
        .o_raddr      (raddr),
        .i_rd_duty    (rd_duty),
        .i_rd_pin     (rd_pin)
    );

    mcpwm_mem #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_waddr   (waddr),
        .i_raddr   (raddr),
        .o_rd_duty (rd_duty),
        .o_rd_pin  (rd_pin)
    );

endmodule
